// ===== hw/rtl/pba_pkg.sv =====
package pba_pkg;

	localparam int NUM_PAGES   = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int PAGE_W      = 12;            // page index bits
	localparam int CNT_W       = 13;            // holds 0..NUM_PAGES
	localparam int WORD_W      = 32;
	localparam int WORD_SHIFT  = 5;
	localparam int NUM_WORDS   = NUM_PAGES / WORD_W;
	localparam int WADDR_W     = PAGE_W - WORD_SHIFT;
	localparam int STEP_W      = WORD_SHIFT + 1;
	localparam int STRIDE_W    = 15;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_MARK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Word-level view of one bitmap access
	typedef struct packed {
		logic [WORD_W-1:0]     mask;
		logic [STEP_W-1:0]     step;
		logic                  used_any;
		logic [WORD_SHIFT-1:0] used_idx;
	} word_info_t;

endpackage

// ===== hw/rtl/page_bitmap_allocator.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type byte_address page_count byte_size align_code
// out      out_valid / out_ready status result_address free_count
//
// Bitmap lives in a 128 x 32 RAM; every word access is a read state, then a use state.
// Allocate: checks each word of each candidate run, steps the candidate by the stride
// past a used page, then clears each word of the run taken. Free/mark: one access per word.
// After reset an init pass fills all 128 RAM words with ones; in_ready stays low meanwhile.
// A beat is taken while the previous result still waits in the output register.
module page_bitmap_allocator
	import pba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [23:0] byte_address,
	input  logic [12:0] page_count,
	input  logic [24:0] byte_size,
	input  logic [3:0]  align_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [23:0] result_address,
	output logic [12:0] free_count
);

	typedef enum logic [8:0] {
		ST_INIT   = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_CHK_RD = 9'b000000100,
		ST_CHK_EV = 9'b000001000,
		ST_ADV    = 9'b000010000,
		ST_WR_RD  = 9'b000100000,
		ST_WR_EV  = 9'b001000000,
		ST_FINISH = 9'b010000000,
		ST_SPARE  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [WADDR_W-1:0]   init_q;
	logic [CNT_W-1:0]     pos_q, end_q, cand_q, first_q, len_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [PAGE_W-1:0]    used_q;
	logic [PAGE_W-1:0]    cursor_q;
	logic [CNT_W-1:0]     free_q;
	logic                 set_q;
	logic                 st_q;
	logic [23:0]          addr_q;
	logic                 out_valid_q;
	logic                 status_q;
	logic [23:0]          result_q;
	logic [CNT_W-1:0]     count_q;

	logic               ram_we;
	logic [WADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;
	word_info_t         winfo;

	pba_map_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pba_word_mask u_mask (
		.pos      (pos_q[PAGE_W-1:0]),
		.end_excl (end_q),
		.word     (ram_rdata),
		.info     (winfo)
	);

	// RAM port steering
	always_comb begin
		ram_raddr = pos_q[PAGE_W-1:WORD_SHIFT];
		ram_waddr = (state_q == ST_INIT) ? init_q : pos_q[PAGE_W-1:WORD_SHIFT];
		ram_we    = (state_q == ST_INIT) || (state_q == ST_WR_EV);
		if (state_q == ST_INIT) begin
			ram_wdata = '1;
		end else if (set_q) begin
			ram_wdata = ram_rdata | winfo.mask;
		end else begin
			ram_wdata = ram_rdata & ~winfo.mask;
		end
	end

	// Request decode
	logic [3:0]          a_shift;
	logic [STRIDE_W-1:0] a_stride;
	logic [PAGE_W-1:0]   a_first_raw;
	logic [CNT_W-1:0]    a_first;
	logic [PAGE_W-1:0]   r_page;
	logic [CNT_W:0]      f_end_raw;
	logic [CNT_W-1:0]    f_end;
	logic [CNT_W-1:0]    f_room;
	logic [CNT_W-1:0]    f_count;
	logic [25:0]         m_sum;
	logic [CNT_W:0]      m_end_raw;
	logic [CNT_W:0]      m_n;
	logic [CNT_W-1:0]    m_end;
	logic [CNT_W-1:0]    m_count;

	always_comb begin
		a_shift     = (align_code == 4'd0) ? 4'd0 : align_code - 4'd1;
		a_stride    = STRIDE_W'(1) << a_shift;
		a_first_raw = cursor_q & ~PAGE_W'(a_stride - STRIDE_W'(1));
		a_first     = ((CNT_W + 1)'(a_first_raw) + (CNT_W + 1)'(page_count)
			> (CNT_W + 1)'(NUM_PAGES)) ? '0 : CNT_W'(a_first_raw);

		r_page    = byte_address[23:PAGE_SHIFT];
		f_end_raw = (CNT_W + 1)'(r_page) + (CNT_W + 1)'(page_count);
		f_end     = (f_end_raw > (CNT_W + 1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
			: CNT_W'(f_end_raw);
		f_room    = CNT_W'(NUM_PAGES) - free_q;
		f_count   = (page_count >= f_room) ? CNT_W'(NUM_PAGES) : free_q + page_count;

		m_sum     = 26'(byte_address) + 26'(byte_size);
		m_end_raw = (CNT_W + 1)'(m_sum >> PAGE_SHIFT);
		m_n       = m_end_raw - (CNT_W + 1)'(r_page);
		m_end     = (m_end_raw > (CNT_W + 1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
			: CNT_W'(m_end_raw);
		m_count   = (m_n >= (CNT_W + 1)'(free_q)) ? '0 : free_q - CNT_W'(m_n);
	end

	// Candidate stepping
	logic [15:0]      adv_raw;
	logic             adv_wrap;
	logic [CNT_W-1:0] adv_next;
	logic [CNT_W-1:0] pos_next;

	always_comb begin
		adv_raw  = 16'(cand_q) + 16'(stride_q);
		adv_wrap = (adv_raw + 16'(len_q)) > 16'(NUM_PAGES);
		adv_next = adv_wrap ? '0 : CNT_W'(adv_raw);
		pos_next = pos_q + CNT_W'(winfo.step);
	end

	assign in_ready = (state_q == ST_IDLE);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			cursor_q <= '0;
			free_q   <= CNT_W'(NUM_PAGES);
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + WADDR_W'(1);
					if (init_q == WADDR_W'(NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						st_q   <= 1'b0;
						addr_q <= '0;
						unique case (req_t'(req_type))
							REQ_ALLOC: begin
								if (page_count == '0) begin
									state_q <= ST_FINISH;
								end else if (page_count > CNT_W'(NUM_PAGES)) begin
									st_q    <= 1'b1;
									state_q <= ST_FINISH;
								end else begin
									stride_q <= a_stride;
									len_q    <= page_count;
									first_q  <= a_first;
									cand_q   <= a_first;
									pos_q    <= a_first;
									end_q    <= a_first + page_count;
									state_q  <= ST_CHK_RD;
								end
							end
							REQ_FREE: begin
								free_q  <= f_count;
								set_q   <= 1'b1;
								pos_q   <= CNT_W'(r_page);
								end_q   <= f_end;
								state_q <= (f_end > CNT_W'(r_page)) ? ST_WR_RD : ST_FINISH;
							end
							REQ_MARK: begin
								free_q  <= m_count;
								set_q   <= 1'b0;
								pos_q   <= CNT_W'(r_page);
								end_q   <= m_end;
								state_q <= (m_end > CNT_W'(r_page)) ? ST_WR_RD : ST_FINISH;
							end
							default: begin
								st_q    <= 1'b1;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EV;
				end
				ST_CHK_EV: begin
					if (winfo.used_any) begin
						used_q  <= {pos_q[PAGE_W-1:WORD_SHIFT], winfo.used_idx};
						state_q <= ST_ADV;
					end else if (pos_next >= end_q) begin
						// Run is free: take it
						pos_q    <= cand_q;
						end_q    <= cand_q + len_q;
						set_q    <= 1'b0;
						cursor_q <= cand_q[PAGE_W-1:0];
						addr_q   <= {cand_q[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
						free_q   <= (len_q >= free_q) ? '0 : free_q - len_q;
						state_q  <= ST_WR_RD;
					end else begin
						pos_q   <= pos_next;
						state_q <= ST_CHK_RD;
					end
				end
				ST_ADV: begin
					if (adv_next == first_q) begin
						cursor_q <= first_q[PAGE_W-1:0];
						st_q     <= 1'b1;
						state_q  <= ST_FINISH;
					end else begin
						cand_q <= adv_next;
						// Candidates at or before the used page cannot fit
						if (!adv_wrap && adv_next <= CNT_W'(used_q)) begin
							state_q <= ST_ADV;
						end else begin
							pos_q   <= adv_next;
							end_q   <= adv_next + len_q;
							state_q <= ST_CHK_RD;
						end
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_EV;
				end
				ST_WR_EV: begin
					pos_q   <= pos_next;
					state_q <= (pos_next >= end_q) ? ST_FINISH : ST_WR_RD;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
			status_q <= st_q;
			result_q <= addr_q;
			count_q  <= free_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_q;
	assign free_count     = count_q;

endmodule

// ===== hw/rtl/pba_map_ram.sv =====
module pba_map_ram
	import pba_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [WADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0]  wdata,
	input  logic [WADDR_W-1:0] raddr,
	output logic [WORD_W-1:0]  rdata
);

	logic [WORD_W-1:0] mem [NUM_WORDS];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/pba_word_mask.sv =====
module pba_word_mask
	import pba_pkg::*;
(
	input  logic [PAGE_W-1:0] pos,
	input  logic [CNT_W-1:0]  end_excl,
	input  logic [WORD_W-1:0] word,
	output word_info_t        info
);

	logic [WORD_SHIFT-1:0] lo;
	logic [CNT_W-1:0]      rem;
	logic [STEP_W-1:0]     room;
	logic [STEP_W-1:0]     n;
	logic [WORD_W-1:0]     used;

	// Bits of this word inside [pos, end_excl); end_excl > pos holds here
	always_comb begin
		lo   = pos[WORD_SHIFT-1:0];
		rem  = end_excl - CNT_W'(pos);
		room = STEP_W'(WORD_W) - STEP_W'(lo);
		n    = (rem < CNT_W'(room)) ? STEP_W'(rem) : room;
		info.step = n;
		info.mask = ({WORD_W{1'b1}} >> (STEP_W'(WORD_W) - n)) << lo;
		used = ~word & info.mask;
		info.used_any = |used;
		info.used_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (used[i]) begin
				info.used_idx = WORD_SHIFT'(i);
			end
		end
	end

endmodule
